### src/msgrb_pkg.sv
// ----------------------------------------------------------------------------
// msgrb_pkg
// Shared codes, field widths and control types for the message commit ring
// buffer.
// ----------------------------------------------------------------------------
package msgrb_pkg;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 8;
    localparam int KIND_W   = 2;
    localparam int OFFSET_W = 10;
    localparam int LENGTH_W = 11;
    localparam int BYTES_W  = 10;

    // request commands
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DONE   = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] RES_COMMIT = 2'd0;
    localparam logic [KIND_W-1:0] RES_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] RES_CHUNK  = 2'd2;

    // state of the output register
    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } out_state_t;

    typedef struct packed {
        logic step;      // apply the accepted request to the ring state
        logic load_out;  // capture the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic has_result; // the request on the input yields a result
    } dp_status_t;

endpackage

### src/msgrb_datapath.sv
// ----------------------------------------------------------------------------
// msgrb_datapath
// Ring positions, message bookkeeping, byte store and result register.
// ----------------------------------------------------------------------------
module msgrb_datapath #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  msgrb_pkg::dp_cmd_t              cmd,
    output msgrb_pkg::dp_status_t           status,
    input  logic [msgrb_pkg::CMD_W-1:0]     in_command,
    input  logic [msgrb_pkg::DATA_W-1:0]    in_data_byte,
    input  logic                            in_last_of_message,
    input  logic                            in_link_ready,
    output logic [msgrb_pkg::KIND_W-1:0]    out_result_kind,
    output logic [msgrb_pkg::OFFSET_W-1:0]  out_chunk_offset,
    output logic [msgrb_pkg::LENGTH_W-1:0]  out_chunk_length,
    output logic [msgrb_pkg::BYTES_W-1:0]   out_message_bytes
);
    import msgrb_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] DEPTH_W = LW'(BUFFER_DEPTH);

    logic [DATA_W-1:0] byte_store [BUFFER_DEPTH];

    logic [AW-1:0] read_pos_reg,   read_pos_next;
    logic [AW-1:0] commit_pos_reg, commit_pos_next;
    logic [AW-1:0] pend_pos_reg,   pend_pos_next;
    logic [AW-1:0] snap_reg,       snap_next;
    logic [AW-1:0] count_reg,      count_next;
    logic          open_reg,       open_next;
    logic          overran_reg,    overran_next;
    logic          busy_reg,       busy_next;

    logic [KIND_W-1:0]   kind_reg,   kind_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic [BYTES_W-1:0]  bytes_reg,  bytes_next;

    logic          is_append, is_tick, is_done;
    logic [AW-1:0] pend_base, snap_base, cnt_base;
    logic          ovr_base;
    logic [LW-1:0] pend_inc;
    logic [AW-1:0] pend_wrap;
    logic          ring_full, take_byte;
    logic [AW-1:0] pend_after, cnt_after;
    logic          ovr_after;
    logic          tick_ok, read_ahead;
    logic [LW-1:0] chunk_len;
    logic [31:0]   cnt_wide, read_wide, len_wide;

    assign is_append = (in_command == CMD_APPEND);
    assign is_tick   = (in_command == CMD_TICK);
    assign is_done   = (in_command == CMD_DONE);

    // open a fresh message from the committed state when none is open
    assign pend_base = open_reg ? pend_pos_reg : commit_pos_reg;
    assign snap_base = open_reg ? snap_reg : read_pos_reg;
    assign ovr_base  = open_reg & overran_reg;
    assign cnt_base  = open_reg ? count_reg : '0;

    assign pend_inc  = {1'b0, pend_base} + LW'(1);
    assign pend_wrap = (pend_inc >= DEPTH_W) ? '0 : pend_inc[AW-1:0];
    assign ring_full = (pend_wrap == snap_base);
    assign take_byte = !ovr_base && !ring_full;

    assign pend_after = take_byte ? pend_wrap : pend_base;
    assign cnt_after  = take_byte ? cnt_base + AW'(1) : cnt_base;
    assign ovr_after  = ovr_base | ring_full;

    assign read_ahead = (read_pos_reg > commit_pos_reg);
    assign tick_ok    = (read_pos_reg != commit_pos_reg) && !busy_reg && in_link_ready;
    // send up to the committed position, or up to the buffer end on wrap
    assign chunk_len  = read_ahead ? DEPTH_W - {1'b0, read_pos_reg}
                                   : {1'b0, commit_pos_reg} - {1'b0, read_pos_reg};

    assign cnt_wide  = 32'(cnt_after);
    assign read_wide = 32'(read_pos_reg);
    assign len_wide  = 32'(chunk_len);

    assign status.has_result = (is_append && in_last_of_message) || (is_tick && tick_ok);

    always_comb begin
        read_pos_next   = read_pos_reg;
        commit_pos_next = commit_pos_reg;
        pend_pos_next   = pend_pos_reg;
        snap_next       = snap_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        overran_next    = overran_reg;
        busy_next       = busy_reg;
        kind_next       = RES_COMMIT;
        offset_next     = '0;
        length_next     = '0;
        bytes_next      = '0;

        if (is_append) begin
            snap_next = snap_base;
            if (in_last_of_message) begin
                open_next    = 1'b0;
                overran_next = 1'b0;
                count_next   = '0;
                if (ovr_after) begin
                    // roll back the whole message
                    pend_pos_next = commit_pos_reg;
                    kind_next     = RES_REJECT;
                end else begin
                    pend_pos_next   = pend_after;
                    commit_pos_next = pend_after;
                    kind_next       = RES_COMMIT;
                    bytes_next      = cnt_wide[BYTES_W-1:0];
                end
            end else begin
                open_next     = 1'b1;
                overran_next  = ovr_after;
                pend_pos_next = pend_after;
                count_next    = cnt_after;
            end
        end else if (is_tick) begin
            if (tick_ok) begin
                busy_next     = 1'b1;
                read_pos_next = read_ahead ? '0 : commit_pos_reg;
                kind_next     = RES_CHUNK;
                offset_next   = read_wide[OFFSET_W-1:0];
                length_next   = len_wide[LENGTH_W-1:0];
            end
        end else if (is_done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_pos_reg   <= '0;
            commit_pos_reg <= '0;
            pend_pos_reg   <= '0;
            snap_reg       <= '0;
            count_reg      <= '0;
            open_reg       <= 1'b0;
            overran_reg    <= 1'b0;
            busy_reg       <= 1'b0;
        end else if (cmd.step) begin
            read_pos_reg   <= read_pos_next;
            commit_pos_reg <= commit_pos_next;
            pend_pos_reg   <= pend_pos_next;
            snap_reg       <= snap_next;
            count_reg      <= count_next;
            open_reg       <= open_next;
            overran_reg    <= overran_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            kind_reg   <= kind_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            bytes_reg  <= bytes_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && is_append && take_byte) begin
            byte_store[pend_base] <= in_data_byte;
        end
    end

    assign out_result_kind   = kind_reg;
    assign out_chunk_offset  = offset_reg;
    assign out_chunk_length  = length_reg;
    assign out_message_bytes = bytes_reg;

    a_closed_pending_at_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> (pend_pos_reg == commit_pos_reg))
        else $error("pending position differs from committed with no open message");

    a_overrun_only_open: assert property (@(posedge aclk) disable iff (!aresetn)
        overran_reg |-> open_reg)
        else $error("overrun flag set outside an open message");

    a_chunk_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && is_tick && tick_ok) |=> busy_reg)
        else $error("sent chunk did not mark the transfer busy");

    a_chunk_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && is_tick) |-> (chunk_len != '0))
        else $error("zero-length chunk sent");

endmodule

### src/msgrb_ctrl.sv
// ----------------------------------------------------------------------------
// msgrb_ctrl
// Handshake controller: tracks the output register and steps the datapath.
// ----------------------------------------------------------------------------
module msgrb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  msgrb_pkg::dp_status_t status,
    output msgrb_pkg::dp_cmd_t    cmd
);
    import msgrb_pkg::*;

    out_state_t state_reg, state_next;
    logic       accept;

    // take a request when the output register is free or being drained
    assign s_ready = (state_reg == ST_EMPTY) || m_ready;
    assign m_valid = (state_reg == ST_FULL);
    assign accept  = s_valid && s_ready;

    assign cmd.step     = accept;
    assign cmd.load_out = accept && status.has_result;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: begin
                if (accept && status.has_result) state_next = ST_FULL;
            end
            ST_FULL: begin
                if (accept && status.has_result) state_next = ST_FULL;
                else if (m_ready)                state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/message_commit_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// message_commit_ring_buffer_unit
// Byte ring buffer with whole-message commit and chunked draining.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one request per handshake: append a byte (with a
//   last-of-message flag), a frame tick (with the link's readiness) or a
//   transmit-done event. Appends build a message that is committed on its
//   last byte, or rolled back if the ring overran while it was open. A tick
//   that finds committed data, no busy transfer and a ready link sends one
//   contiguous chunk; transmit-done clears busy.
//   The m_ channel returns at most one result per request: committed (with
//   the message length), rejected, or chunk sent (offset and length).
//   Latency: a result is presented the cycle after its request is taken.
//   Throughput: one request per cycle while the receiver does not stall, set
//   by the update of the ring positions and one byte-store write port.
//   Reset clears all positions, the open message and busy flag, and drops
//   any held result; the byte store is not cleared.
//   While the receiver stalls, the result is held and further requests wait.
// ----------------------------------------------------------------------------
module message_commit_ring_buffer_unit #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [msgrb_pkg::CMD_W-1:0]     s_command,
    input  logic [msgrb_pkg::DATA_W-1:0]    s_data_byte,
    input  logic                            s_last_of_message,
    input  logic                            s_link_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [msgrb_pkg::KIND_W-1:0]    m_result_kind,
    output logic [msgrb_pkg::OFFSET_W-1:0]  m_chunk_offset,
    output logic [msgrb_pkg::LENGTH_W-1:0]  m_chunk_length,
    output logic [msgrb_pkg::BYTES_W-1:0]   m_message_bytes
);
    import msgrb_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    msgrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    msgrb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (dp_cmd),
        .status             (dp_status),
        .in_command         (s_command),
        .in_data_byte       (s_data_byte),
        .in_last_of_message (s_last_of_message),
        .in_link_ready      (s_link_ready),
        .out_result_kind    (m_result_kind),
        .out_chunk_offset   (m_chunk_offset),
        .out_chunk_length   (m_chunk_length),
        .out_message_bytes  (m_message_bytes)
    );

endmodule

### dv/msgrb_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msgrb_result_checker
// Watches both channels of the message commit ring buffer. It keeps its own
// copy of the ring positions, works out the result of each accepted request
// and compares every accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module msgrb_result_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [msgrb_pkg::CMD_W-1:0]    s_command,
    input  logic [msgrb_pkg::DATA_W-1:0]   s_data_byte,
    input  logic                          s_last_of_message,
    input  logic                          s_link_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [msgrb_pkg::KIND_W-1:0]   m_result_kind,
    input  logic [msgrb_pkg::OFFSET_W-1:0] m_chunk_offset,
    input  logic [msgrb_pkg::LENGTH_W-1:0] m_chunk_length,
    input  logic [msgrb_pkg::BYTES_W-1:0]  m_message_bytes,
    output int                            error_count,
    output int                            pending_results,
    output int                            commit_count,
    output int                            reject_count,
    output int                            chunk_count
);
    import msgrb_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [BYTES_W-1:0]  msg_bytes;
    } ring_result_t;

    ring_result_t expected_results[$];

    int unsigned rd_pos;
    int unsigned wr_commit;
    int unsigned wr_pend;
    int unsigned rd_snap;
    int unsigned msg_len;
    bit          msg_open;
    bit          msg_overrun;
    bit          xfer_busy;

    initial begin
        error_count     = 0;
        pending_results = 0;
        commit_count    = 0;
        reject_count    = 0;
        chunk_count     = 0;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Apply one request to the ring copy and return the result it causes.
    task automatic advance_ring(input logic [CMD_W-1:0] cmd, input logic last,
                                input logic link, output bit produced,
                                output ring_result_t res);
        int unsigned nxt;
        int unsigned span;
        produced = 1'b0;
        res      = '0;
        case (cmd)
            CMD_APPEND: begin
                if (!msg_open) begin
                    msg_open    = 1'b1;
                    wr_pend     = wr_commit;
                    rd_snap     = rd_pos;
                    msg_overrun = 1'b0;
                    msg_len     = 0;
                end
                if (!msg_overrun) begin
                    nxt = (wr_pend + 1 >= DEPTH) ? 0 : wr_pend + 1;
                    // keep one slot free against the read position seen at open
                    if (nxt == rd_snap) begin
                        msg_overrun = 1'b1;
                    end else begin
                        wr_pend = nxt;
                        msg_len++;
                    end
                end
                if (last) begin
                    msg_open = 1'b0;
                    produced = 1'b1;
                    if (msg_overrun) begin
                        wr_pend     = wr_commit;
                        msg_overrun = 1'b0;
                        res.kind    = RES_REJECT;
                    end else begin
                        wr_commit     = wr_pend;
                        res.kind      = RES_COMMIT;
                        res.msg_bytes = BYTES_W'(msg_len);
                    end
                    msg_len = 0;
                end
            end
            CMD_TICK: begin
                if (rd_pos != wr_commit && !xfer_busy && link) begin
                    // send up to the committed position or to the ring end
                    span = (rd_pos > wr_commit) ? DEPTH - rd_pos : wr_commit - rd_pos;
                    produced   = 1'b1;
                    res.kind   = RES_CHUNK;
                    res.offset = OFFSET_W'(rd_pos);
                    res.length = LENGTH_W'(span);
                    xfer_busy  = 1'b1;
                    rd_pos     = rd_pos + span;
                    if (rd_pos >= DEPTH) rd_pos = 0;
                end
            end
            CMD_DONE: begin
                xfer_busy = 1'b0;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        ring_result_t want;
        ring_result_t made;
        bit           produced;
        if (!aresetn) begin
            rd_pos      = 0;
            wr_commit   = 0;
            wr_pend     = 0;
            rd_snap     = 0;
            msg_len     = 0;
            msg_open    = 1'b0;
            msg_overrun = 1'b0;
            xfer_busy   = 1'b0;
            expected_results.delete();
        end else begin
            // a result seen here belongs to an earlier request, so check it first
            if (m_valid && m_ready) begin
                if (m_result_kind == RES_COMMIT) commit_count++;
                else if (m_result_kind == RES_REJECT) reject_count++;
                else if (m_result_kind == RES_CHUNK) chunk_count++;
                if (expected_results.size() == 0) begin
                    $error("result kind %0d arrived with none outstanding", m_result_kind);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("m_result_kind", int'(want.kind), int'(m_result_kind));
                    check_field("m_chunk_offset", int'(want.offset), int'(m_chunk_offset));
                    check_field("m_chunk_length", int'(want.length), int'(m_chunk_length));
                    check_field("m_message_bytes", int'(want.msg_bytes),
                                int'(m_message_bytes));
                end
            end
            if (s_valid && s_ready) begin
                advance_ring(s_command, s_last_of_message, s_link_ready, produced, made);
                if (produced) expected_results.push_back(made);
            end
        end
        pending_results = expected_results.size();
    end

endmodule

### dv/message_commit_ring_buffer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_commit_ring_buffer_unit_tb
// Drives appends, frame ticks and transmit-done requests into the ring
// buffer with random gaps and receiver stalls. A directed opening covers the
// corner cases; random epochs then fill the ring to overrun, drain it across
// the wrap point and interleave ticks with open messages.
// ----------------------------------------------------------------------------
module message_commit_ring_buffer_unit_tb;
    import msgrb_pkg::*;

    localparam int               RING_DEPTH   = 1024;
    localparam int               TARGET_ITEMS = 1850;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic [DATA_W-1:0]   s_data_byte;
    logic                s_last_of_message;
    logic                s_link_ready;
    logic                m_valid;
    logic                m_ready;
    logic [KIND_W-1:0]   m_result_kind;
    logic [OFFSET_W-1:0] m_chunk_offset;
    logic [LENGTH_W-1:0] m_chunk_length;
    logic [BYTES_W-1:0]  m_message_bytes;

    int error_count;
    int pending_results;
    int commit_count;
    int reject_count;
    int chunk_count;

    int items_sent  = 0;
    int stall_left  = 0;
    bit src_steady  = 1'b0;
    bit recv_steady = 1'b0;
    bit hold_done   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    message_commit_ring_buffer_unit #(
        .BUFFER_DEPTH(RING_DEPTH)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_data_byte      (s_data_byte),
        .s_last_of_message(s_last_of_message),
        .s_link_ready     (s_link_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_chunk_offset   (m_chunk_offset),
        .m_chunk_length   (m_chunk_length),
        .m_message_bytes  (m_message_bytes)
    );

    msgrb_result_checker #(
        .DEPTH(RING_DEPTH)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_data_byte      (s_data_byte),
        .s_last_of_message(s_last_of_message),
        .s_link_ready     (s_link_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_chunk_offset   (m_chunk_offset),
        .m_chunk_length   (m_chunk_length),
        .m_message_bytes  (m_message_bytes),
        .error_count      (error_count),
        .pending_results  (pending_results),
        .commit_count     (commit_count),
        .reject_count     (reject_count),
        .chunk_count      (chunk_count)
    );

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!recv_steady && $urandom_range(0, 3) == 0) stall_left <= pick_gap(1'b0);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
                         input logic last, input logic link);
        int gap;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_data_byte       <= data;
        s_last_of_message <= last;
        s_link_ready      <= link;
        do @(posedge aclk); while (!s_ready);
        if (cmd != CMD_UNUSED) items_sent++;
        @(negedge aclk);
    endtask

    // Random content; ticks and done requests may land inside the message.
    task automatic append_message(input int len, input bit mixed);
        for (int i = 0; i < len; i++) begin
            if (mixed && i > 0 && $urandom_range(0, 11) == 0) begin
                if (!hold_done && $urandom_range(0, 1) == 0)
                    issue(CMD_DONE, 8'($urandom), 1'($urandom), 1'($urandom));
                else
                    issue(CMD_TICK, 8'($urandom), 1'($urandom), 1'b1);
            end
            issue(CMD_APPEND, 8'($urandom), i == len - 1, 1'($urandom));
        end
    endtask

    initial begin
        int epoch;
        int epoch_end;
        int r;
        s_valid           = 1'b0;
        s_command         = CMD_APPEND;
        s_data_byte       = '0;
        s_last_of_message = 1'b0;
        s_link_ready      = 1'b0;
        m_ready           = 1'b0;
        aresetn           = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // tick on an empty ring, then a one-byte and a two-byte message at both data extremes
        issue(CMD_TICK,   8'h00, 1'b0, 1'b1);
        issue(CMD_APPEND, 8'h00, 1'b1, 1'b0);
        issue(CMD_TICK,   8'hff, 1'b1, 1'b0);
        issue(CMD_TICK,   8'h00, 1'b0, 1'b1);
        issue(CMD_APPEND, 8'hff, 1'b0, 1'b1);
        issue(CMD_APPEND, 8'ha5, 1'b1, 1'b0);
        // busy transfer blocks the tick until done
        issue(CMD_TICK,   8'h5a, 1'b0, 1'b1);
        issue(CMD_DONE,   8'hff, 1'b1, 1'b1);
        issue(CMD_TICK,   8'h00, 1'b0, 1'b1);
        issue(CMD_DONE,   8'h00, 1'b0, 1'b0);
        issue(CMD_DONE,   8'h00, 1'b0, 1'b0);
        issue(CMD_UNUSED, 8'hff, 1'b1, 1'b1);
        issue(CMD_UNUSED, 8'h00, 1'b0, 1'b0);
        // tick and done while a message is open; the snapshot stays old
        issue(CMD_APPEND, 8'h11, 1'b1, 1'b1);
        issue(CMD_APPEND, 8'h22, 1'b0, 1'b0);
        issue(CMD_TICK,   8'h33, 1'b0, 1'b1);
        issue(CMD_DONE,   8'h44, 1'b0, 1'b0);
        issue(CMD_APPEND, 8'h80, 1'b0, 1'b1);
        issue(CMD_APPEND, 8'h7f, 1'b1, 1'b0);
        issue(CMD_TICK,   8'h01, 1'b1, 1'b1);
        issue(CMD_DONE,   8'hfe, 1'b1, 1'b1);

        // The first epoch withholds done so the ring fills to overrun.
        epoch = 0;
        while (items_sent < TARGET_ITEMS) begin
            hold_done   = (epoch == 0) || ($urandom_range(0, 5) == 0);
            src_steady  = ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            epoch_end   = items_sent + ((epoch == 0) ? 1200 : $urandom_range(100, 300));
            while (items_sent < epoch_end && items_sent < TARGET_ITEMS + 100) begin
                r = $urandom_range(0, 99);
                if (r < (hold_done ? 90 : 60)) begin
                    if ($urandom_range(0, 99) < 85)
                        append_message($urandom_range(1, 16), $urandom_range(0, 3) == 0);
                    else
                        append_message($urandom_range(40, 200), $urandom_range(0, 3) == 0);
                end else if (r < 80) begin
                    issue(CMD_TICK, 8'($urandom), 1'($urandom), $urandom_range(0, 4) != 0);
                end else if (r < 95) begin
                    if (hold_done)
                        issue(CMD_TICK, 8'($urandom), 1'($urandom), 1'b1);
                    else
                        issue(CMD_DONE, 8'($urandom), 1'($urandom), 1'($urandom));
                end else begin
                    // noise: unused code or a tick the link refuses
                    if ($urandom_range(0, 1) == 0)
                        issue(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
                    else
                        issue(CMD_TICK, 8'($urandom), 1'($urandom), 1'b0);
                end
            end
            epoch++;
        end
        s_valid <= 1'b0;

        while (pending_results != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        $display("Sent %0d requests over %0d epochs; results: %0d committed,",
                 items_sent, epoch, commit_count);
        $display("%0d rejected, %0d chunks; mismatches and stray results: %0d",
                 reject_count, chunk_count, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d results outstanding", pending_results);
        $display("== FAIL ==");
        $finish;
    end

endmodule
